// File: rtl/xafu_pkg.sv
// ----------------------------------------------------------------------------
// xafu_pkg
// Types, codes and the flags-word encoder shared by the arithmetic flag unit.
// ----------------------------------------------------------------------------
package xafu_pkg;

  // Action codes carried with every item
  typedef enum logic [1:0] {
    ACT_EVAL_ALL  = 2'd0,
    ACT_EVAL_KEEP = 2'd1,
    ACT_WRITE     = 2'd2,
    ACT_NONE      = 2'd3
  } xafu_action_t;

  // Operation kinds
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_ADD   = 4'd1,
    OP_ADC   = 4'd2,
    OP_SBB   = 4'd3,
    OP_SUB   = 4'd4,
    OP_LOGIC = 4'd5,
    OP_SHL   = 4'd6,
    OP_DSHL  = 4'd7,
    OP_SHR   = 4'd8,
    OP_DSHR  = 4'd9,
    OP_SAR   = 4'd10,
    OP_INC   = 4'd11,
    OP_DEC   = 4'd12,
    OP_NEG   = 4'd13,
    OP_VALUE = 4'd14,
    OP_MULDIV = 4'd15
  } xafu_op_t;

  // Operand size codes
  localparam logic [1:0] WC_BYTE = 2'd0;
  localparam logic [1:0] WC_WORD = 2'd1;

  // Register indexes on the configuration port
  localparam logic REG_BASE_WORD   = 1'b0;
  localparam logic REG_SYSTEM_BITS = 1'b1;

  // Flag positions in the encoded word
  localparam int unsigned POS_CF   = 0;
  localparam int unsigned POS_PF   = 2;
  localparam int unsigned POS_AF   = 4;
  localparam int unsigned POS_ZF   = 6;
  localparam int unsigned POS_SF   = 7;
  localparam int unsigned POS_TF   = 8;
  localparam int unsigned POS_IF   = 9;
  localparam int unsigned POS_DF   = 10;
  localparam int unsigned POS_OF   = 11;
  localparam int unsigned POS_IOPL = 12;
  localparam int unsigned POS_NT   = 14;
  localparam int unsigned POS_VM   = 17;
  localparam int unsigned POS_AC   = 18;
  localparam int unsigned POS_ID   = 21;

  typedef struct packed {
    logic cf;
    logic pf;
    logic af;
    logic zf;
    logic sf;
    logic of;
    logic tf;
    logic intr;
    logic df;
    logic nt;
  } xafu_flags_t;

  function automatic logic [31:0] encode_flags(input xafu_flags_t f,
                                               input logic [31:0] base,
                                               input logic [4:0]  sys);
    logic [31:0] w;
    w = base;
    w[POS_CF]          = w[POS_CF]          | f.cf;
    w[POS_PF]          = w[POS_PF]          | f.pf;
    w[POS_AF]          = w[POS_AF]          | f.af;
    w[POS_ZF]          = w[POS_ZF]          | f.zf;
    w[POS_SF]          = w[POS_SF]          | f.sf;
    w[POS_TF]          = w[POS_TF]          | f.tf;
    w[POS_IF]          = w[POS_IF]          | f.intr;
    w[POS_DF]          = w[POS_DF]          | f.df;
    w[POS_OF]          = w[POS_OF]          | f.of;
    w[POS_IOPL]        = w[POS_IOPL]        | sys[0];
    w[POS_IOPL+1]      = w[POS_IOPL+1]      | sys[1];
    w[POS_NT]          = w[POS_NT]          | f.nt;
    w[POS_VM]          = w[POS_VM]          | sys[3];
    w[POS_AC]          = w[POS_AC]          | sys[2];
    w[POS_ID]          = w[POS_ID]          | sys[4];
    return w;
  endfunction

endpackage

// File: rtl/x86_arith_flag_unit.sv
// ----------------------------------------------------------------------------
// x86_arith_flag_unit
// Eager x86 status-flag evaluation, one operation record per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one operation record per transaction. tuser carries
//   the action and the operation kind, tdata the operand size, operands,
//   result, incoming carry and the word for a flags load.
//   Output stream (m_*): one transaction per input, the encoded 32-bit flags
//   word after that item, in input order.
//   Configuration (APB): base_word at 0x0, system_bits at 0x4; write only
//   while no item is in flight. pready is tied high, reads are zero-wait.
// Path: an accepted item goes from the input register through the flag
//   logic into the flags and output registers once the output is free,
//   and waits in the input register until then.
// Throughput: one item per cycle while m_tready stays high. The flags
//   register feeds its own next value, so each item sees the flags left
//   by the one before.
// Reset: clears the flags, both configuration registers and both valid bits.
// Stall: with m_tready low the result holds; the input register fills and
//   then s_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module x86_arith_flag_unit
  import xafu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] width_code, [33:2] operand_a, [65:34] operand_b,
  // [97:66] result_value, [98] carry_in, [130:99] write_word, [135:131] zero
  input  logic [135:0] s_tdata,
  // [1:0] action, [5:2] op_kind
  input  logic [5:0]   s_tuser,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] flags_word
  output logic [31:0]  m_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // Configuration registers
  logic [31:0] base_word;
  logic [4:0]  system_bits;

  // Input register
  logic        in_valid;
  logic [1:0]  in_action;
  logic [3:0]  in_op_kind;
  logic [1:0]  in_width_code;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic [31:0] in_result_value;
  logic        in_carry_in;
  logic [31:0] in_write_word;

  // Flag state
  xafu_flags_t flags;
  xafu_flags_t flags_next;

  logic        advance;
  logic        cfg_write;

  // Advance the input register whenever the output register is free or
  // being emptied this cycle
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_word   <= '0;
      system_bits <= '0;
    end else if (cfg_write) begin
      // Decode on the register index bit only
      unique case (paddr[2])
        REG_BASE_WORD:   base_word   <= pwdata;
        REG_SYSTEM_BITS: system_bits <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE_WORD:   prdata = base_word;
      REG_SYSTEM_BITS: prdata = {27'd0, system_bits};
    endcase
  end

  // ---------------------------------------------------------- input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Payload: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action       <= s_tuser[1:0];
      in_op_kind      <= s_tuser[5:2];
      in_width_code   <= s_tdata[1:0];
      in_operand_a    <= s_tdata[33:2];
      in_operand_b    <= s_tdata[65:34];
      in_result_value <= s_tdata[97:66];
      in_carry_in     <= s_tdata[98];
      in_write_word   <= s_tdata[130:99];
    end
  end

  // ---------------------------------------------------------- flag logic
  xafu_eval u_eval (
    .action       (in_action),
    .op_kind      (in_op_kind),
    .width_code   (in_width_code),
    .operand_a    (in_operand_a),
    .operand_b    (in_operand_b),
    .result_value (in_result_value),
    .carry_in     (in_carry_in),
    .write_word   (in_write_word),
    .flags        (flags),
    .flags_next   (flags_next)
  );

  // ------------------------------------------------ flags and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      flags    <= flags_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result word while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= encode_flags(flags_next, base_word, system_bits);
    end
  end

endmodule

// File: rtl/xafu_eval.sv
// ----------------------------------------------------------------------------
// xafu_eval
// Next-state logic for the flags: evaluates one operation record against the
// current flags and returns the flags after the item.
// ----------------------------------------------------------------------------
module xafu_eval
  import xafu_pkg::*;
(
  input  logic [1:0]  action,
  input  logic [3:0]  op_kind,
  input  logic [1:0]  width_code,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [31:0] result_value,
  input  logic        carry_in,
  input  logic [31:0] write_word,
  input  xafu_flags_t flags,
  output xafu_flags_t flags_next
);

  logic [31:0] mask;
  logic [31:0] msb;
  logic [5:0]  wid;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] r;
  logic [7:0]  cnt;
  logic        cnt_in_w;
  logic        cnt_in_32;
  logic [5:0]  idx_shl;
  logic [5:0]  idx_dshl;
  logic [5:0]  idx_shr;
  logic        sh_af;
  logic        add_af;
  logic        rz;
  logic        rs;
  logic        rp;
  logic        a_sign;
  logic        std_zsp;
  logic        cf;
  logic        pf;
  logic        af;
  logic        zf;
  logic        sf;
  logic        of;

  always_comb begin
    unique case (width_code)
      WC_BYTE: begin
        mask = 32'h0000_00ff;
        msb  = 32'h0000_0080;
        wid  = 6'd8;
      end
      WC_WORD: begin
        mask = 32'h0000_ffff;
        msb  = 32'h0000_8000;
        wid  = 6'd16;
      end
      default: begin
        mask = 32'hffff_ffff;
        msb  = 32'h8000_0000;
        wid  = 6'd32;
      end
    endcase
  end

  assign a      = operand_a & mask;
  assign b      = operand_b & mask;
  assign r      = result_value & mask;
  assign cnt    = operand_b[7:0];
  assign cnt_in_w  = (cnt != 8'd0) && (cnt <= {2'b00, wid});
  assign cnt_in_32 = (cnt != 8'd0) && (cnt <= 8'd32);
  assign idx_shl  = wid - cnt[5:0];
  assign idx_dshl = 6'd32 - cnt[5:0];
  assign idx_shr  = cnt[5:0] - 6'd1;
  assign sh_af  = (operand_b[4:0] != 5'd0);
  assign add_af = a[4] ^ b[4] ^ r[4];
  assign rz     = (r == 32'd0);
  assign rs     = ((r & msb) != 32'd0);
  assign rp     = ~^r[7:0];
  assign a_sign = ((a & msb) != 32'd0);

  always_comb begin
    cf      = flags.cf;
    pf      = flags.pf;
    af      = flags.af;
    zf      = flags.zf;
    sf      = flags.sf;
    of      = flags.of;
    std_zsp = 1'b1;
    unique case (xafu_op_t'(op_kind))
      OP_ADD: begin
        cf = (r < a);
        af = add_af;
        of = (((a ^ b ^ msb) & (r ^ a) & msb) != 32'd0);
      end
      OP_ADC: begin
        // Compare at full operand width, carry-in widens to or-equal
        cf = (r < a) || (r < b) || (carry_in && ((r <= a) || (r <= b)));
        af = add_af;
        of = (((a ^ b ^ msb) & (r ^ a) & msb) != 32'd0);
      end
      OP_SBB: begin
        cf = (a < r) || (carry_in && (b == mask));
        af = add_af;
        of = (((a ^ b) & (a ^ r) & msb) != 32'd0);
      end
      OP_SUB: begin
        cf = (a < b);
        af = add_af;
        of = (((a ^ b) & (a ^ r) & msb) != 32'd0);
      end
      OP_LOGIC: begin
        cf = 1'b0;
        af = 1'b0;
        of = 1'b0;
      end
      OP_SHL: begin
        cf = cnt_in_w ? a[idx_shl[4:0]] : 1'b0;
        of = rs ^ cf;
        af = sh_af;
      end
      OP_DSHL: begin
        cf = cnt_in_32 ? operand_a[idx_dshl[4:0]] : 1'b0;
        of = (((r ^ a) & msb) != 32'd0);
      end
      OP_SHR: begin
        cf = cnt_in_w ? a[idx_shr[4:0]] : 1'b0;
        of = (operand_b[4:0] == 5'd1) ? a_sign : 1'b0;
        af = sh_af;
      end
      OP_DSHR: begin
        cf = cnt_in_32 ? operand_a[idx_shr[4:0]] : 1'b0;
        of = (((r ^ a) & msb) != 32'd0);
      end
      OP_SAR: begin
        // Count beyond the width shifts out copies of the sign
        if (cnt == 8'd0) begin
          cf = 1'b0;
        end else if (cnt > {2'b00, wid}) begin
          cf = a_sign;
        end else begin
          cf = a[idx_shr[4:0]];
        end
        of = 1'b0;
        af = sh_af;
      end
      OP_INC: begin
        af = (r[3:0] == 4'h0);
        of = (r == msb);
      end
      OP_DEC: begin
        af = (r[3:0] == 4'hf);
        of = (r == (msb - 32'd1));
      end
      OP_NEG: begin
        cf = (a != 32'd0);
        af = (r[3:0] != 4'h0);
        of = (a == msb);
      end
      OP_VALUE: begin
        zf      = rz;
        sf      = rs;
        std_zsp = 1'b0;
      end
      OP_NONE, OP_MULDIV: begin
        std_zsp = 1'b0;
      end
    endcase
    if (std_zsp) begin
      zf = rz;
      sf = rs;
      pf = rp;
    end
  end

  always_comb begin
    flags_next = flags;
    unique case (xafu_action_t'(action))
      ACT_EVAL_ALL: begin
        flags_next.cf = cf;
        flags_next.of = of;
        flags_next.pf = pf;
        flags_next.af = af;
        flags_next.zf = zf;
        flags_next.sf = sf;
      end
      ACT_EVAL_KEEP: begin
        flags_next.pf = pf;
        flags_next.af = af;
        flags_next.zf = zf;
        flags_next.sf = sf;
      end
      ACT_WRITE: begin
        flags_next.cf   = write_word[POS_CF];
        flags_next.pf   = write_word[POS_PF];
        flags_next.af   = write_word[POS_AF];
        flags_next.zf   = write_word[POS_ZF];
        flags_next.sf   = write_word[POS_SF];
        flags_next.tf   = write_word[POS_TF];
        flags_next.intr = write_word[POS_IF];
        flags_next.df   = write_word[POS_DF];
        flags_next.of   = write_word[POS_OF];
        flags_next.nt   = write_word[POS_NT];
      end
      ACT_NONE: begin
        flags_next = flags;
      end
    endcase
  end

endmodule

// File: rtl/xafu_checker.sv
// ----------------------------------------------------------------------------
// xafu_checker
// Port-level checks for the flag unit, bound to the top level.
// ----------------------------------------------------------------------------
module xafu_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [135:0] s_tdata,
  input logic [5:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  // Output stream is empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Base word reads back what was written
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2] |=>
      paddr[2] || (prdata == $past(pwdata)))
    else $error("base word readback mismatch");

  // System bits keep five bits of the written data
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] |=>
      !paddr[2] || (prdata == ($past(pwdata) & 32'h0000_001f)))
    else $error("system bits readback mismatch");

endmodule

bind x86_arith_flag_unit xafu_checker u_xafu_checker (.*);

// File: verif/tb_x86_arith_flag_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_x86_arith_flag_unit
// Self-checking bench for the eager x86 status-flag unit.
// ----------------------------------------------------------------------------
// Drives operation records into the input stream, keeps a flag-level model of
// the unit in a small scoreboard and compares every flags word that leaves
// the output stream. Runs a directed set of corner records, then random
// records under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
import xafu_pkg::*;

typedef struct packed {
  xafu_action_t action;
  xafu_op_t     kind;
  logic [1:0]   wc;
  logic [31:0]  a;
  logic [31:0]  b;
  logic [31:0]  r;
  logic         cin;
  logic [31:0]  ww;
} flag_rec_t;

class flag_scoreboard;
  bit cf, pf, af, zf, sf, of, tf, ief, df, nt;
  logic [31:0] base_word;
  logic [4:0]  system_bits;
  logic [31:0] expected_words[$];
  int unsigned mismatches;
  int unsigned words_checked;

  function new();
    {cf, pf, af, zf, sf, of, tf, ief, df, nt} = '0;
    base_word     = '0;
    system_bits   = '0;
    mismatches    = 0;
    words_checked = 0;
  endfunction

  function void write_register(logic idx, logic [31:0] value);
    case (idx)
      REG_BASE_WORD:   base_word = value;
      REG_SYSTEM_BITS: system_bits = value[4:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] encoded_word();
    logic [31:0] w;
    w = base_word;
    w[POS_CF]     |= cf;
    w[POS_PF]     |= pf;
    w[POS_AF]     |= af;
    w[POS_ZF]     |= zf;
    w[POS_SF]     |= sf;
    w[POS_TF]     |= tf;
    w[POS_IF]     |= ief;
    w[POS_DF]     |= df;
    w[POS_OF]     |= of;
    w[POS_IOPL]   |= system_bits[0];
    w[POS_IOPL+1] |= system_bits[1];
    w[POS_NT]     |= nt;
    w[POS_VM]     |= system_bits[3];
    w[POS_AC]     |= system_bits[2];
    w[POS_ID]     |= system_bits[4];
    return w;
  endfunction

  // Update the flags for one accepted record and queue the word it yields
  function void evaluate_record(flag_rec_t rec);
    int unsigned w;
    logic [31:0] mask, msb, a, b, r, x;
    logic [7:0]  cnt;
    bit sh_af, add_af, rz, rs, rp, std_zsp;
    bit ncf, npf, naf, nzf, nsf, nof;
    if (rec.action == ACT_WRITE) begin
      cf  = rec.ww[POS_CF];
      pf  = rec.ww[POS_PF];
      af  = rec.ww[POS_AF];
      zf  = rec.ww[POS_ZF];
      sf  = rec.ww[POS_SF];
      tf  = rec.ww[POS_TF];
      ief = rec.ww[POS_IF];
      df  = rec.ww[POS_DF];
      of  = rec.ww[POS_OF];
      nt  = rec.ww[POS_NT];
    end else if (rec.action == ACT_EVAL_ALL || rec.action == ACT_EVAL_KEEP) begin
      w    = (rec.wc == WC_BYTE) ? 8 : (rec.wc == WC_WORD) ? 16 : 32;
      mask = (w == 32) ? 32'hffff_ffff : ((32'd1 << w) - 32'd1);
      msb  = 32'd1 << (w - 1);
      a    = rec.a & mask;
      b    = rec.b & mask;
      r    = rec.r & mask;
      x    = a ^ b ^ r;
      cnt  = rec.b[7:0];
      sh_af  = |rec.b[4:0];
      add_af = x[4];
      rz   = (r == 0);
      rs   = |(r & msb);
      rp   = ~^r[7:0];
      ncf = cf; npf = pf; naf = af; nzf = zf; nsf = sf; nof = of;
      std_zsp = 1'b1;
      case (rec.kind)
        OP_ADD: begin
          ncf = (r < a);
          naf = add_af;
          nof = |((a ^ b ^ msb) & (r ^ a) & msb);
        end
        OP_ADC: begin
          ncf = (r < a) || (r < b) || (rec.cin && ((r <= a) || (r <= b)));
          naf = add_af;
          nof = |((a ^ b ^ msb) & (r ^ a) & msb);
        end
        OP_SBB: begin
          ncf = (a < r) || (rec.cin && (b == mask));
          naf = add_af;
          nof = |((a ^ b) & (a ^ r) & msb);
        end
        OP_SUB: begin
          ncf = (a < b);
          naf = add_af;
          nof = |((a ^ b) & (a ^ r) & msb);
        end
        OP_LOGIC: begin
          ncf = 1'b0; naf = 1'b0; nof = 1'b0;
        end
        OP_SHL: begin
          ncf = (cnt >= 1 && cnt <= w) ? a[w - cnt] : 1'b0;
          nof = rs ^ ncf;
          naf = sh_af;
        end
        OP_DSHL: begin
          // carry comes from the full 32-bit operand, auxiliary untouched
          ncf = (cnt >= 1 && cnt <= 32) ? rec.a[32 - cnt] : 1'b0;
          nof = |((r ^ a) & msb);
        end
        OP_SHR: begin
          ncf = (cnt >= 1 && cnt <= w) ? a[cnt - 1] : 1'b0;
          nof = (rec.b[4:0] == 5'd1) ? |(a & msb) : 1'b0;
          naf = sh_af;
        end
        OP_DSHR: begin
          ncf = (cnt >= 1 && cnt <= 32) ? rec.a[cnt - 1] : 1'b0;
          nof = |((r ^ a) & msb);
        end
        OP_SAR: begin
          if (cnt == 0) ncf = 1'b0;
          else if (cnt > w) ncf = |(a & msb);
          else ncf = a[cnt - 1];
          nof = 1'b0;
          naf = sh_af;
        end
        OP_INC: begin
          naf = (r[3:0] == 4'h0);
          nof = (r == msb);
        end
        OP_DEC: begin
          naf = (r[3:0] == 4'hf);
          nof = (r == msb - 32'd1);
        end
        OP_NEG: begin
          ncf = (a != 0);
          naf = (r[3:0] != 4'h0);
          nof = (a == msb);
        end
        OP_VALUE: begin
          nzf = rz; nsf = rs;
          std_zsp = 1'b0;
        end
        default: std_zsp = 1'b0;
      endcase
      if (std_zsp) begin
        nzf = rz; nsf = rs; npf = rp;
      end
      if (rec.action == ACT_EVAL_ALL) begin
        cf = ncf; of = nof;
      end
      pf = npf; af = naf; zf = nzf; sf = nsf;
    end
    expected_words.push_back(encoded_word());
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] error: %s", $realtime, msg);
  endtask

  task check_word(logic [31:0] got);
    logic [31:0] want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("flags word %h arrived with none expected", got));
    end else begin
      want = expected_words.pop_front();
      words_checked++;
      if (got !== want)
        report_mismatch($sformatf("flags_word got %h want %h (diff %h)",
                                  got, want, got ^ want));
    end
  endtask
endclass

module tb_x86_arith_flag_unit;

  localparam logic [1:0] WC_DWORD = 2'd2;
  localparam logic [1:0] WC_SPARE = 2'd3;   // unused code, behaves as doubleword

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // [1:0] width_code, [33:2] operand_a, [65:34] operand_b,
  // [97:66] result_value, [98] carry_in, [130:99] write_word, [135:131] zero
  logic [135:0] s_tdata;
  // [1:0] action, [5:2] op_kind
  logic [5:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // [31:0] flags_word
  logic [31:0]  m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  flag_scoreboard sb;
  int unsigned    idle_pct;
  int unsigned    records_sent;
  int unsigned    settings_used;

  x86_arith_flag_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: decide back-pressure at the falling edge so it is stable well
  // before the next rising edge; idle_pct of zero keeps it ready throughout.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Take every output transaction at the rising edge and hand it to the
  // scoreboard; values seen here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  // Safety net: a hung handshake ends the run as a failure
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Register write: setup cycle, then access cycle; the register takes the
  // value at the edge where psel, penable, pwrite and pready are all high.
  // Close with psel and penable low so the next transfer starts on a fresh edge.
  task automatic apb_write(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Register read-back, compared against the scoreboard's copy
  task automatic apb_read_check(logic idx);
    logic [31:0] want;
    want = (idx == REG_BASE_WORD) ? sb.base_word : {27'd0, sb.system_bits};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report_mismatch($sformatf("register %0d read %h want %h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Load both registers and read them back; only called while idle
  task automatic load_settings(logic [31:0] base, logic [4:0] sys);
    apb_write(REG_BASE_WORD, base);
    apb_write(REG_SYSTEM_BITS, {27'd0, sys});
    apb_read_check(REG_BASE_WORD);
    apb_read_check(REG_SYSTEM_BITS);
    settings_used++;
  endtask

  // Hand one record to the unit. Entered at a falling edge, leaves at one.
  // Gaps drop tvalid for whole cycles; a record that follows straight on
  // keeps tvalid high, so it is never lowered and raised in one step.
  task automatic send_record(flag_rec_t rec);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {rec.kind, rec.action};
    s_tdata  <= {5'd0, rec.ww, rec.cin, rec.r, rec.b, rec.a, rec.wc};
    do @(posedge clk); while (!s_tready);
    sb.evaluate_record(rec);
    records_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid, wait for every flags word to come back, then let the
  // pipeline settle before any register is touched.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic flag_rec_t make_rec(xafu_action_t action, xafu_op_t kind,
                                         logic [1:0] wc, logic [31:0] a,
                                         logic [31:0] b, logic [31:0] r,
                                         logic cin, logic [31:0] ww);
    flag_rec_t rec;
    rec.action = action;
    rec.kind   = kind;
    rec.wc     = wc;
    rec.a      = a;
    rec.b      = b;
    rec.r      = r;
    rec.cin    = cin;
    rec.ww     = ww;
    return rec;
  endfunction

  // Operands lean on the edges of the range now and then
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly consistent records (result computed from the operands, so the
  // flags land on real corner values), the rest with an arbitrary result.
  function automatic flag_rec_t random_record();
    flag_rec_t   rec;
    int unsigned sel;
    logic [31:0] mask;
    logic [7:0]  cnt;
    sel = $urandom_range(0, 99);
    rec.action = (sel < 45) ? ACT_EVAL_ALL :
                 (sel < 80) ? ACT_EVAL_KEEP :
                 (sel < 94) ? ACT_WRITE : ACT_NONE;
    rec.kind = xafu_op_t'(4'($urandom_range(0, 15)));
    rec.wc   = ($urandom_range(0, 99) < 6) ? WC_SPARE : 2'($urandom_range(0, 2));
    rec.a    = pick_operand();
    rec.b    = pick_operand();
    rec.cin  = 1'($urandom_range(0, 1));
    rec.ww   = $urandom;
    if (rec.kind inside {OP_SHL, OP_DSHL, OP_SHR, OP_DSHR, OP_SAR} &&
        $urandom_range(0, 99) < 80)
      rec.b = ($urandom & 32'hffff_ff00) | $urandom_range(0, 40);
    mask = (rec.wc == WC_BYTE) ? 32'h0000_00ff :
           (rec.wc == WC_WORD) ? 32'h0000_ffff : 32'hffff_ffff;
    cnt  = rec.b[7:0];
    if ($urandom_range(0, 99) < 75) begin
      case (rec.kind)
        OP_ADD:   rec.r = rec.a + rec.b;
        OP_ADC:   rec.r = rec.a + rec.b + rec.cin;
        OP_SBB:   rec.r = rec.a - rec.b - rec.cin;
        OP_SUB:   rec.r = rec.a - rec.b;
        OP_LOGIC: rec.r = rec.a ^ rec.b;
        OP_SHL:   rec.r = rec.a << cnt;
        OP_SHR:   rec.r = (rec.a & mask) >> cnt;
        OP_INC:   rec.r = rec.a + 32'd1;
        OP_DEC:   rec.r = rec.a - 32'd1;
        OP_NEG:   rec.r = -rec.a;
        default:  rec.r = $urandom;
      endcase
    end else begin
      rec.r = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    end
    return rec;
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_record(random_record());
  endtask

  // Corner records: flags load both ways, every kind, carries and overflows
  // at each width, shift counts of zero, equal to and beyond the width, the
  // adc wrap at full width, the keep mode, the spare width and action codes.
  task automatic run_directed();
    send_record(make_rec(ACT_WRITE, OP_NONE, WC_BYTE, '0, '0, '0, 1'b0, 32'hffff_ffff));
    send_record(make_rec(ACT_WRITE, OP_NONE, WC_BYTE, '1, '1, '1, 1'b1, 32'h0000_0000));
    send_record(make_rec(ACT_EVAL_ALL, OP_ADD, WC_BYTE, 32'hff, 32'h01, 32'h00, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_ADD, WC_WORD, 32'h7fff, 32'h1, 32'h8000, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_ADC, WC_DWORD, '1, '0, '0, 1'b1, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_ADC, WC_BYTE, 32'hff, 32'hff, 32'hff, 1'b1, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SBB, WC_BYTE, 32'h00, 32'hff, 32'h00, 1'b1, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SUB, WC_DWORD, 32'h0, 32'h1, '1, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_LOGIC, WC_WORD, 32'hffff, 32'h0, 32'h0, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SHL, WC_BYTE, 32'h81, 32'h08, 32'h00, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SHL, WC_DWORD, '1, 32'h100, '1, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SHL, WC_WORD, 32'hffff, 32'h21, 32'h0, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_DSHL, WC_BYTE, 32'h8000_0000, 32'h20, 32'h80,
                         1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SHR, WC_BYTE, 32'h80, 32'h01, 32'h40, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SHR, WC_WORD, 32'hffff, 32'hff, 32'h0, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_DSHR, WC_DWORD, 32'h1, 32'h1, 32'h8000_0000,
                         1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SAR, WC_BYTE, 32'h80, 32'h09, 32'hff, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_SAR, WC_DWORD, 32'h8000_0000, 32'h0,
                         32'h8000_0000, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_INC, WC_WORD, 32'h7fff, 32'h0, 32'h8000, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_DEC, WC_BYTE, 32'h80, 32'h0, 32'h7f, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_NEG, WC_DWORD, 32'h8000_0000, 32'h0,
                         32'h8000_0000, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_NEG, WC_BYTE, 32'h0, 32'h0, 32'h0, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_VALUE, WC_SPARE, '0, '0, 32'h8000_0000, 1'b0, '0));
    send_record(make_rec(ACT_EVAL_ALL, OP_MULDIV, WC_DWORD, '1, '1, '0, 1'b1, '0));
    send_record(make_rec(ACT_EVAL_KEEP, OP_SUB, WC_BYTE, 32'h00, 32'h01, 32'hff, 1'b0, '0));
    send_record(make_rec(ACT_NONE, OP_ADD, WC_SPARE, '1, '1, '0, 1'b1, '1));
  endtask

  initial begin
    // every input known from time zero, reset held high before the run starts
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct      = 23;
    records_sent  = 0;
    settings_used = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all-zero registers: corners first, then random records
    load_settings(32'h0000_0000, 5'd0);
    run_directed();
    run_random(250);
    drain_pipeline();

    // every fixed bit set: the flags word reads all ones whatever the flags are
    load_settings(32'hffff_ffff, 5'h1f);
    run_random(150);
    drain_pipeline();

    // long stretch with both sides streaming flat out
    idle_pct = 0;
    load_settings($urandom, 5'($urandom_range(0, 31)));
    run_random(300);
    drain_pipeline();
    idle_pct = 23;

    // sparse fixed bits, all system bits set
    load_settings($urandom & $urandom, 5'h1f);
    run_random(150);
    drain_pipeline();

    load_settings($urandom & $urandom & $urandom, 5'($urandom_range(0, 31)));
    run_random(150);
    drain_pipeline();

    $display("run covered %0d operation records under %0d register settings",
             records_sent, settings_used);
    $display("%0d flags words compared, %0d mismatches", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
